// ----- sv/apt_pkg.sv -----
// Shared constants and types for the affine point transform.
package apt_pkg;

  // Default arithmetic format: signed Q16.16 in 32-bit words.
  localparam int DEF_WORD_BITS = 32;
  localparam int DEF_FRAC_BITS = 16;

  // Fixed port widths.
  localparam int FIELD_BITS   = 32;
  localparam int REG_BITS     = 64;
  localparam int HALF_BITS    = REG_BITS / 2;
  localparam int NUM_ROWS     = 3;
  localparam int NUM_COLS     = 4;
  localparam int NUM_REGS     = 2 * NUM_ROWS;
  localparam int REG_IDX_BITS = $clog2(NUM_REGS);

  typedef logic [REG_BITS-1:0]     cfg_word_t;
  typedef logic [REG_IDX_BITS-1:0] cfg_idx_t;

  // Identity transform at reset.
  localparam cfg_word_t REG_RESET [NUM_REGS] = '{
    64'd65536, 64'd0,
    64'd281474976710656, 64'd0,
    64'd0, 64'd65536
  };

endpackage

// ----- sv/apt_vec_if.sv -----
// Input vector channel: valid/ready handshake with the four vector components.
interface apt_vec_if import apt_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [FIELD_BITS-1:0] in_x;
  logic signed [FIELD_BITS-1:0] in_y;
  logic signed [FIELD_BITS-1:0] in_z;
  logic signed [FIELD_BITS-1:0] in_w;

  modport source (output valid, in_x, in_y, in_z, in_w, input ready);
  modport sink   (input valid, in_x, in_y, in_z, in_w, output ready);
endinterface

// ----- sv/apt_res_if.sv -----
// Result channel: valid/ready handshake with the transformed components and clip flag.
interface apt_res_if import apt_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [FIELD_BITS-1:0] out_x;
  logic signed [FIELD_BITS-1:0] out_y;
  logic signed [FIELD_BITS-1:0] out_z;
  logic                         clipped;

  modport source (output valid, out_x, out_y, out_z, clipped, input ready);
  modport sink   (input valid, out_x, out_y, out_z, clipped, output ready);
endinterface

// ----- sv/affine_point_transform.sv -----
// 3x4 affine matrix times vector in signed fixed point, four-stage pipeline.
// An input transfer reaches res through the four register stages in order:
// products, pair sums, shifted row sums and outputs.
// Throughput: one vector per cycle while res is ready; each stage advances on its own
// when the next one is empty or moving, so bubbles close up under output stalls.
// Reset (synchronous, rst high): empties every stage and loads the identity
// matrix into the six row registers.
module affine_point_transform import apt_pkg::*; #(
  parameter int WORD_BITS = DEF_WORD_BITS,
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  cfg_idx_t        cfg_index,
  input  cfg_word_t       cfg_data,
  apt_vec_if.sink         vec,
  apt_res_if.source       res
);

  localparam int PROD_BITS = 2 * WORD_BITS;      // one product
  localparam int PAIR_BITS = PROD_BITS + 1;      // sum of two products
  localparam int SUM_BITS  = PROD_BITS + 2;      // sum of four products

  // ------------------------------------------------------------------
  // Matrix registers. The user must write them only while the pipeline is idle; the
  // block does not enforce this, and the multipliers read them directly. Indexes past the list are dropped.
  // ------------------------------------------------------------------
  cfg_word_t row_regs [NUM_REGS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) row_regs[i] <= REG_RESET[i];
    end else if (cfg_we && (cfg_index < REG_IDX_BITS'(NUM_REGS))) begin
      row_regs[cfg_index] <= cfg_data;
    end
  end

  // Coefficients: low WORD_BITS of each 32-bit half, taken as signed.
  logic signed [WORD_BITS-1:0] coef [NUM_ROWS][NUM_COLS];
  logic signed [WORD_BITS-1:0] comp [NUM_COLS];

  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      coef[r][0] = row_regs[2*r][WORD_BITS-1:0];
      coef[r][1] = row_regs[2*r][HALF_BITS+WORD_BITS-1:HALF_BITS];
      coef[r][2] = row_regs[2*r+1][WORD_BITS-1:0];
      coef[r][3] = row_regs[2*r+1][HALF_BITS+WORD_BITS-1:HALF_BITS];
    end
    comp[0] = vec.in_x[WORD_BITS-1:0];
    comp[1] = vec.in_y[WORD_BITS-1:0];
    comp[2] = vec.in_z[WORD_BITS-1:0];
    comp[3] = vec.in_w[WORD_BITS-1:0];
  end

  // ------------------------------------------------------------------
  // Stage handshake: a stage may take new data when it is empty or its
  // content moves on in the same cycle.
  // ------------------------------------------------------------------
  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4      = !v4 || res.ready;
  assign rdy3      = !v3 || rdy4;
  assign rdy2      = !v2 || rdy3;
  assign rdy1      = !v1 || rdy2;
  assign vec.ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= vec.valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  // Stage 1: twelve products, one multiplier per matrix entry.
  logic signed [PROD_BITS-1:0] prod [NUM_ROWS][NUM_COLS];

  always_ff @(posedge clk) begin
    if (vec.valid && rdy1) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        for (int k = 0; k < NUM_COLS; k++) begin
          prod[r][k] <= PROD_BITS'(coef[r][k]) * PROD_BITS'(comp[k]);
        end
      end
    end
  end

  // Stage 2: add products in pairs, exact.
  logic signed [PAIR_BITS-1:0] pair [NUM_ROWS][2];

  always_ff @(posedge clk) begin
    if (v1 && rdy2) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        pair[r][0] <= PAIR_BITS'(prod[r][0]) + PAIR_BITS'(prod[r][1]);
        pair[r][1] <= PAIR_BITS'(prod[r][2]) + PAIR_BITS'(prod[r][3]);
      end
    end
  end

  // Stage 3: full row sum, then drop the fraction with an arithmetic shift
  // (rounds toward minus infinity).
  logic signed [SUM_BITS-1:0] shifted [NUM_ROWS];

  always_ff @(posedge clk) begin
    if (v2 && rdy3) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        shifted[r] <= (SUM_BITS'(pair[r][0]) + SUM_BITS'(pair[r][1])) >>> FRAC_BITS;
      end
    end
  end

  // Stage 4: saturate to WORD_BITS signed and sign-extend to the port width.
  // A value fits when every bit from the word's sign bit upwards agrees.
  logic signed [WORD_BITS-1:0] sat_val [NUM_ROWS];
  logic [NUM_ROWS-1:0]         over;

  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      over[r] = !((&shifted[r][SUM_BITS-1:WORD_BITS-1]) ||
                  !(|shifted[r][SUM_BITS-1:WORD_BITS-1]));
      if (!over[r]) begin
        sat_val[r] = shifted[r][WORD_BITS-1:0];
      end else if (shifted[r][SUM_BITS-1]) begin
        sat_val[r] = {1'b1, {(WORD_BITS-1){1'b0}}};
      end else begin
        sat_val[r] = {1'b0, {(WORD_BITS-1){1'b1}}};
      end
    end
  end

  logic signed [FIELD_BITS-1:0] out_x, out_y, out_z;
  logic                         clipped;

  always_ff @(posedge clk) begin
    if (v3 && rdy4) begin
      out_x   <= FIELD_BITS'(sat_val[0]);
      out_y   <= FIELD_BITS'(sat_val[1]);
      out_z   <= FIELD_BITS'(sat_val[2]);
      clipped <= |over;
    end
  end

  assign res.valid   = v4;
  assign res.out_x   = out_x;
  assign res.out_y   = out_y;
  assign res.out_z   = out_z;
  assign res.clipped = clipped;

endmodule

// ----- tb/sv/apt_transform_check.sv -----
`timescale 1ns / 100ps
// Scoreboard for the affine point transform: predicts every result from the vector transfers.
module apt_transform_check import apt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_we,
  input  cfg_idx_t  cfg_index,
  input  cfg_word_t cfg_data,
  apt_vec_if        vec,
  apt_res_if        res,
  output int        points_pending,
  output int        fail_count
);

  localparam int ACC_BITS = 2 * FIELD_BITS + 8;

  typedef logic signed [FIELD_BITS-1:0] word_t;
  typedef struct packed {
    word_t x;
    word_t y;
    word_t z;
    logic  clipped;
  } point_t;

  cfg_word_t matrix [NUM_REGS];
  point_t    expected_points [$];

  // Column 0/1 sit in the left register of a row, column 2 and the
  // translation in the right one; low half first.
  function automatic word_t coef(input int row, input int col);
    cfg_word_t r;
    r = matrix[2 * row + col / 2];
    return (col % 2) ? word_t'(r[REG_BITS-1:HALF_BITS]) : word_t'(r[HALF_BITS-1:0]);
  endfunction

  // Exact sum of the four products, floor shift, then saturate each row.
  function automatic point_t transform_point(input word_t vx, vy, vz, vw);
    logic signed [ACC_BITS-1:0] acc, c_w, v_w, hi_lim, lo_lim;
    word_t  vin  [NUM_COLS];
    word_t  outs [NUM_ROWS];
    point_t p;
    vin    = '{vx, vy, vz, vw};
    hi_lim = (ACC_BITS'(1) <<< (DEF_WORD_BITS - 1)) - 1;
    lo_lim = -hi_lim - 1;
    p.clipped = 1'b0;
    for (int r = 0; r < NUM_ROWS; r++) begin
      acc = '0;
      for (int k = 0; k < NUM_COLS; k++) begin
        c_w = coef(r, k);
        v_w = vin[k];
        acc += c_w * v_w;
      end
      acc = acc >>> DEF_FRAC_BITS;
      if (acc > hi_lim) begin
        acc = hi_lim;
        p.clipped = 1'b1;
      end else if (acc < lo_lim) begin
        acc = lo_lim;
        p.clipped = 1'b1;
      end
      outs[r] = acc[FIELD_BITS-1:0];
    end
    p.x = outs[0];
    p.y = outs[1];
    p.z = outs[2];
    return p;
  endfunction

  function automatic int field_miss(input string name, input word_t want, input word_t got);
    if (want === got) return 0;
    $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    return 1;
  endfunction

  always @(posedge clk) begin
    point_t want;
    int     errs;
    errs = 0;
    if (rst) begin
      foreach (matrix[i]) matrix[i] = REG_RESET[i];
      expected_points.delete();
      fail_count <= 0;
    end else begin
      if (res.valid && res.ready) begin
        if (expected_points.size() == 0) begin
          $display("%0t: unexpected result x=%0d y=%0d z=%0d clipped=%0b", $time,
                   res.out_x, res.out_y, res.out_z, res.clipped);
          errs++;
        end else begin
          want = expected_points.pop_front();
          errs += field_miss("out_x", want.x, res.out_x);
          errs += field_miss("out_y", want.y, res.out_y);
          errs += field_miss("out_z", want.z, res.out_z);
          errs += field_miss("clipped", word_t'(want.clipped), word_t'(res.clipped));
        end
      end
      if (vec.valid && vec.ready)
        expected_points.push_back(transform_point(vec.in_x, vec.in_y, vec.in_z, vec.in_w));
      if (cfg_we && cfg_index < NUM_REGS)
        matrix[cfg_index] = cfg_data;
      fail_count <= fail_count + errs;
    end
    points_pending <= expected_points.size();
  end

endmodule

// ----- tb/sv/affine_point_transform_test.sv -----
`timescale 1ns / 100ps
// Top of the affine point transform testbench: clock, reset, stimulus and verdict.
module affine_point_transform_test;
  import apt_pkg::*;

  localparam int LATENCY     = 4;
  localparam int LONG_HOLD   = 64;
  localparam int PHASE_ITEMS = 50;
  localparam int NUM_PHASES  = 8;

  typedef logic signed [FIELD_BITS-1:0] word_t;

  // Register indexes; the last two lie past the register list.
  typedef enum logic [REG_IDX_BITS-1:0] {
    ROW0_LEFT, ROW0_RIGHT, ROW1_LEFT, ROW1_RIGHT, ROW2_LEFT, ROW2_RIGHT,
    PAST_END_LO, PAST_END_HI
  } reg_sel_e;

  localparam word_t W_MAX = word_t'(32'h7FFF_FFFF);
  localparam word_t W_MIN = word_t'(32'h8000_0000);
  localparam word_t ONE   = word_t'(32'h0001_0000);

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      cfg_we;
  cfg_idx_t  cfg_index;
  cfg_word_t cfg_data;
  int        points_pending;
  int        fail_count;

  // Idling knobs, set per phase by the stimulus and read by both sides.
  int src_gap_pct    = 0;
  int sink_stall_pct = 0;
  bit hold_req       = 1'b0;

  apt_vec_if vec_ch ();
  apt_res_if res_ch ();

  affine_point_transform u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .vec       (vec_ch.sink),
    .res       (res_ch.source)
  );

  apt_transform_check u_check (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .vec            (vec_ch),
    .res            (res_ch),
    .points_pending (points_pending),
    .fail_count     (fail_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Hard stop in case the handshakes lock up.
  initial begin
    #1_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Result side: ready in random bursts, or one long hold-off on request so that
  // the pipeline fills and pushes back on the vector channel.
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        res_ch.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        res_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        res_ch.ready <= 1'b1;
      end else if (sink_stall_pct > 0 && $urandom_range(99) < sink_stall_pct) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        res_ch.ready <= 1'b1;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // Offer one vector, possibly after a random gap, and hold it until the transfer.
  task automatic send_vec(input word_t x, y, z, w);
    if (src_gap_pct > 0 && $urandom_range(99) < src_gap_pct) begin
      vec_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    vec_ch.valid <= 1'b1;
    vec_ch.in_x  <= x;
    vec_ch.in_y  <= y;
    vec_ch.in_z  <= z;
    vec_ch.in_w  <= w;
    do @(posedge clk); while (!vec_ch.ready);
  endtask

  // Drop valid and wait until every predicted result has been transferred.
  task automatic wait_drained();
    vec_ch.valid <= 1'b0;
    do @(posedge clk); while (points_pending != 0);
  endtask

  // Leave the write enable high; the caller lowers it after the last write.
  task automatic write_reg(input reg_sel_e sel, input cfg_word_t data);
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic load_matrix(input cfg_word_t m [NUM_REGS]);
    foreach (m[i]) write_reg(reg_sel_e'(i), m[i]);
    cfg_we <= 1'b0;
  endtask

  function automatic word_t rand_small();
    word_t v;
    v = $urandom;
    return v >>> 11;
  endfunction

  // Bias towards the limits, unity and zero; the rest is small or fully random.
  function automatic word_t rand_coef();
    case ($urandom_range(5))
      0:       return W_MAX;
      1:       return W_MIN;
      2:       return '0;
      3:       return ONE;
      4:       return rand_small();
      default: return $urandom;
    endcase
  endfunction

  function automatic word_t rand_field();
    case ($urandom_range(9))
      0:       return W_MAX;
      1:       return W_MIN;
      2:       return '0;
      3:       return ONE;
      4, 5:    return rand_small();
      default: return $urandom;
    endcase
  endfunction

  function automatic int pick_pct();
    int choices [4] = '{0, 10, 30, 60};
    return choices[$urandom_range(3)];
  endfunction

  initial begin
    cfg_word_t m [NUM_REGS];
    vec_ch.valid <= 1'b0;
    vec_ch.in_x  <= '0;
    vec_ch.in_y  <= '0;
    vec_ch.in_z  <= '0;
    vec_ch.in_w  <= '0;
    cfg_we       <= 1'b0;
    cfg_index    <= ROW0_LEFT;
    cfg_data     <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Identity from reset: every output must equal its input, never clipped.
    send_vec('0, '0, '0, '0);
    send_vec(W_MAX, W_MAX, W_MAX, W_MAX);
    send_vec(W_MIN, W_MIN, W_MIN, W_MIN);
    send_vec(-1, -1, -1, -1);
    send_vec(word_t'(32'h1234_5678), -ONE, ONE / 2, ONE);
    send_vec(W_MAX, W_MIN, '0, ONE);
    send_vec(ONE, ONE, ONE, ONE);

    // Writes past the register list must leave the identity untouched.
    wait_drained();
    write_reg(PAST_END_LO, '1);
    write_reg(PAST_END_HI, '1);
    cfg_we <= 1'b0;
    send_vec(W_MAX, W_MIN, ONE, ONE);
    send_vec(123456, -7, -65537, '0);

    // Tiny coefficients: negative sums must round towards minus infinity.
    wait_drained();
    m = '{ {32'd1, 32'd1},               {32'hFFFF_FFFF, 32'd1},
           {32'd0, 32'hFFFF_FFFF},       {32'd3, 32'h0001_8000},
           {32'hFFFF_0000, 32'h0000_8000}, {32'h8000_0000, 32'd7} };
    load_matrix(m);
    send_vec(-1, '0, '0, '0);
    send_vec('0, '0, '0, 1);
    send_vec(-65537, 1, 3, '0);
    send_vec(W_MIN, W_MAX, -3, '0);

    // Largest positive coefficients: overflow in both directions.
    wait_drained();
    m = '{default: 64'h7FFF_FFFF_7FFF_FFFF};
    load_matrix(m);
    send_vec(W_MAX, W_MAX, W_MAX, W_MAX);
    send_vec(W_MIN, W_MIN, W_MIN, W_MIN);
    send_vec(1, '0, '0, '0);
    send_vec(W_MAX, W_MIN, W_MAX, W_MIN);

    // Most negative coefficients.
    wait_drained();
    m = '{default: 64'h8000_0000_8000_0000};
    load_matrix(m);
    send_vec(W_MIN, W_MIN, W_MIN, W_MIN);
    send_vec(W_MAX, W_MAX, W_MAX, W_MAX);
    send_vec(-1, -1, -1, -1);
    send_vec('0, '0, '0, W_MIN);

    // Random matrices and vectors, a fresh idling profile per phase. Phase 1
    // streams without gaps into a long result hold-off; phase 4 pauses
    // half-way until drained; the last phase runs with no idling at all.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_drained();
      foreach (m[i]) m[i] = {rand_coef(), rand_coef()};
      load_matrix(m);
      if (ph == NUM_PHASES - 1) begin
        src_gap_pct    = 0;
        sink_stall_pct = 0;
      end else begin
        src_gap_pct    = (ph == 1) ? 0 : pick_pct();
        sink_stall_pct = pick_pct();
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 1 && n == 10)
          hold_req = 1'b1;
        if (ph == 4 && n == PHASE_ITEMS / 2)
          wait_drained();
        send_vec(rand_field(), rand_field(), rand_field(), rand_field());
      end
    end

    // Drain, then give stray results time to show up.
    wait_drained();
    repeat (LATENCY + 4) @(posedge clk);
    if (fail_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
